### hw/rtl/jfp_pkg.sv
// ---------------------------------------------------------------------------
// jfp_pkg: shared types and constants
// Character codes, event codes and joystick decode constants for the parser.
// ---------------------------------------------------------------------------
package jfp_pkg;

   localparam logic [7:0] CHR_STX     = 8'h02;
   localparam logic [7:0] CHR_ETX     = 8'h03;
   localparam logic [7:0] BYTE_MAX_OK = 8'd127;
   localparam logic [6:0] CHR_A       = 7'h41;
   localparam logic [6:0] CHR_L       = 7'h4C;

   localparam int FRAME_SLOTS = 8;
   localparam int POS_W       = 4;

   localparam logic [POS_W-1:0] POS_IDLE   = 4'd0;
   localparam logic [POS_W-1:0] POS_BUTTON = 4'd2;
   localparam logic [POS_W-1:0] POS_STICK  = 4'd7;
   localparam logic [POS_W-1:0] POS_FULL   = 4'd8;

   // bit index of the momentary button, never changed
   localparam logic [2:0] BIT_MOMENTARY = 3'd4;

   // digit sum h*100 + t*10 + u over raw codes; offset removes the ASCII
   // zero from all three digits and the stick offset of 200
   localparam int ASCII_ZERO   = 48;
   localparam int STICK_OFFSET = 200;
   localparam int STICK_LIMIT  = 100;
   localparam int SUM_W        = 14;
   localparam logic [SUM_W-1:0] SUM_BIAS = SUM_W'(111 * ASCII_ZERO + STICK_OFFSET);
   localparam logic [SUM_W-1:0] SUM_LOW  = SUM_W'(111 * ASCII_ZERO + STICK_OFFSET
                                                 - STICK_LIMIT);
   localparam logic [SUM_W-1:0] SUM_HIGH = SUM_W'(111 * ASCII_ZERO + STICK_OFFSET
                                                 + STICK_LIMIT);

   typedef enum logic [2:0] {
      EV_STORED = 3'd0,
      EV_STICK  = 3'd1,
      EV_BUTTON = 3'd2,
      EV_DROP   = 3'd3,
      EV_IGNORE = 3'd4
   } event_type;

   typedef struct packed {
      logic              ok;
      logic signed [7:0] value;
   } stick_result_type;

endpackage

### hw/rtl/joystick_frame_parser_unit.sv
// ---------------------------------------------------------------------------
// joystick_frame_parser_unit: STX/ETX framed joystick and button parser
// Parses one serial byte per request and returns the stored stick and button
// state with an event code for every byte.
// ---------------------------------------------------------------------------
// Pipeline: the request passes the input register, then the response register;
//    frame state updates as the byte moves across.
// Throughput: one request per cycle unless rsp_tready stalls the response slot.
// Reset: synchronous, active high; waits for STX, stick and buttons cleared.
//    Stored frame bytes are not cleared; they are always written before read.
module joystick_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] joy_x, [15:8] joy_y,
                                    // [21:16] buttons, [24:22] event_res, rest 0
);
   import jfp_pkg::*;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // response stage
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;

   // frame state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [6:0]       bytes_ff [FRAME_SLOTS];
   logic [7:0]       stick_x_ff, stick_x_in;
   logic [7:0]       stick_y_ff, stick_y_in;
   logic [5:0]       buttons_ff, buttons_in;

   logic             advance;
   logic             store;
   event_type        ev;
   stick_result_type res_x, res_y;
   logic [5:0]       buttons_upd;

   // the input stage moves on whenever the response slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   jfp_stick_calc u_calc_x (
      .digit_h (bytes_ff[1]),
      .digit_t (bytes_ff[2]),
      .digit_u (bytes_ff[3]),
      .result  (res_x)
   );

   jfp_stick_calc u_calc_y (
      .digit_h (bytes_ff[4]),
      .digit_t (bytes_ff[5]),
      .digit_u (bytes_ff[6]),
      .result  (res_y)
   );

   jfp_button_update u_buttons (
      .letter      (bytes_ff[1]),
      .buttons_cur (buttons_ff),
      .buttons_new (buttons_upd)
   );

   // per-byte frame logic
   always_comb begin
      pos_in     = pos_ff;
      stick_x_in = stick_x_ff;
      stick_y_in = stick_y_ff;
      buttons_in = buttons_ff;
      store      = 1'b0;
      ev         = EV_STORED;
      if ((pos_ff == POS_IDLE) && (in_byte_ff != CHR_STX)) begin
         ev = EV_IGNORE;
      end else if ((in_byte_ff > BYTE_MAX_OK) || (pos_ff >= POS_FULL)) begin
         // high byte or overlong frame
         pos_in = POS_IDLE;
         ev     = EV_DROP;
      end else if (in_byte_ff == CHR_ETX) begin
         pos_in = POS_IDLE;
         ev     = EV_DROP;
         if (pos_ff == POS_STICK) begin
            if (res_x.ok && res_y.ok) begin
               stick_x_in = res_x.value;
               stick_y_in = res_y.value;
               ev         = EV_STICK;
            end
         end else if (pos_ff == POS_BUTTON) begin
            buttons_in = buttons_upd;
            ev         = EV_BUTTON;
         end
      end else begin
         store  = 1'b1;
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = {7'd0, ev, buttons_in, stick_y_in, stick_x_in};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_IDLE;
         stick_x_ff   <= 8'd0;
         stick_y_ff   <= 8'd0;
         buttons_ff   <= 6'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pos_ff     <= pos_in;
            stick_x_ff <= stick_x_in;
            stick_y_ff <= stick_y_in;
            buttons_ff <= buttons_in;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
      if (advance && store) begin
         bytes_ff[pos_ff[2:0]] <= in_byte_ff[6:0];
      end
   end

endmodule

### hw/rtl/jfp_stick_calc.sv
// ---------------------------------------------------------------------------
// jfp_stick_calc: three-digit axis decode
// Weights three stored codes 100/10/1, removes offsets and range checks.
// ---------------------------------------------------------------------------
module jfp_stick_calc (
   input  logic [6:0]                digit_h,
   input  logic [6:0]                digit_t,
   input  logic [6:0]                digit_u,
   output jfp_pkg::stick_result_type result
);
   import jfp_pkg::*;

   logic [SUM_W-1:0] sum;

   always_comb begin
      sum = SUM_W'(digit_h) * SUM_W'(100) + SUM_W'(digit_t) * SUM_W'(10)
          + SUM_W'(digit_u);
      result.ok    = (sum >= SUM_LOW) && (sum <= SUM_HIGH);
      result.value = 8'(sum - SUM_BIAS);
   end

endmodule

### hw/rtl/jfp_button_update.sv
// ---------------------------------------------------------------------------
// jfp_button_update: button letter decode
// Letters A..L set (even) or clear (odd) bits 0..5; I/J and bit 4 untouched.
// ---------------------------------------------------------------------------
module jfp_button_update (
   input  logic [6:0] letter,
   input  logic [5:0] buttons_cur,
   output logic [5:0] buttons_new
);
   import jfp_pkg::*;

   logic [6:0] idx;
   logic [2:0] bit_sel;
   logic [5:0] mask;

   always_comb begin
      idx         = letter - CHR_A;
      bit_sel     = idx[3:1];
      mask        = 6'b1 << bit_sel;
      buttons_new = buttons_cur;
      if ((letter >= CHR_A) && (letter <= CHR_L) && (bit_sel != BIT_MOMENTARY)) begin
         if (!idx[0]) begin
            buttons_new = buttons_cur | mask;
         end else begin
            buttons_new = buttons_cur & ~mask;
         end
      end
   end

endmodule
